>>> hdl/awvn_pkg.sv
// shared types and constants of the area weighted vertex normals block
package awvn_pkg;

   localparam int NODES   = 1024;
   localparam int ADDR_W  = $clog2(NODES);
   localparam int COORD_W = 24;
   localparam int ACC_W   = 56;
   localparam int NORM_W  = 16;

   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int CROSS_W   = PROD_W + 1;
   localparam int VTX_W     = 3 * COORD_W;
   localparam int ACC_ENT_W = 3 * ACC_W + 1;
   localparam int MAG_W     = 30;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUM_W     = 2 * MAG_W + 2;
   localparam int ROOT_W    = MAG_W + 2;
   localparam int BIT_W     = 2 * ROOT_W - 1;
   localparam int QUO_W     = NORM_W + 1;
   localparam int NUM_W     = MAG_W + NORM_W;
   localparam int CNT_W     = (ADDR_W > 6) ? ADDR_W : 6;

   localparam logic [1:0] CORNER_LAST = 2'd2;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_TRI   = 2'd2,
      ACT_READ  = 2'd3
   } awvn_action_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_VRD_A,
      ST_VRD_B,
      ST_VRD_C,
      ST_DIFF,
      ST_CROSS,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_R_RD,
      ST_R_MAG,
      ST_SHIFT,
      ST_SQUARE,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV_IT,
      ST_DIV_END,
      ST_RSP
   } awvn_state_type;

   typedef struct packed {
      logic             capture_req;
      logic             vtx_write;
      logic             vtx_read;
      logic             cap_a;
      logic             cap_b;
      logic             diff;
      logic             cross_step;
      logic             acc_clear;
      logic             acc_read;
      logic             acc_write;
      logic             res_oor;
      logic             mag_load;
      logic             shift;
      logic             sq_step;
      logic             sqrt_step;
      logic             div_init;
      logic             div_step;
      logic             q_store;
      logic             rsp_load;
      logic [1:0]       corner;
      logic [CNT_W-1:0] cnt;
   } awvn_cmd_type;

   typedef struct packed {
      logic a_ok;
      logic tri_ok;
      logic zero;
      logic need_shift;
      logic rsp_busy;
   } awvn_stat_type;

endpackage

>>> hdl/area_weighted_vertex_normals_core.sv
// top level of the area weighted vertex normals block
// a read applies a right shift s (0..26) that brings the largest accumulator below 2^30,
// then runs the 32 step root and three 17 step divides before it raises rsp_tvalid
// reset: a clearing pass zeroes all 1024 accumulators, with req_tready low
// a finished result waits in the output register while the next transaction is taken
module area_weighted_vertex_normals_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // pos_x[23:0], pos_y[47:24], pos_z[71:48], node_a[81:72], node_b[91:82],
   // node_c[101:92], zero fill above
   input  logic [103:0]  req_tdata,
   // action[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // normal_x[15:0], normal_y[31:16], normal_z[47:32], degenerate[48],
   // saturated[49], zero fill above
   output logic [55:0]   rsp_tdata
);
   import awvn_pkg::*;

   awvn_cmd_type  cmd;
   awvn_stat_type stat;

   logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
   logic                     degenerate, saturated;

   // sequencer: walks each transaction through the datapath
   awvn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (req_tuser),
      .req_ready  (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath: vertex and accumulator memories, cross product, root and divide
   awvn_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_pos_x      (req_tdata[23:0]),
      .req_pos_y      (req_tdata[47:24]),
      .req_pos_z      (req_tdata[71:48]),
      .req_node_a     (req_tdata[81:72]),
      .req_node_b     (req_tdata[91:82]),
      .req_node_c     (req_tdata[101:92]),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_normal_x   (normal_x),
      .rsp_normal_y   (normal_y),
      .rsp_normal_z   (normal_z),
      .rsp_degenerate (degenerate),
      .rsp_saturated  (saturated)
   );

   // pack result fields, lowest first
   assign rsp_tdata = {6'd0, saturated, degenerate, normal_z, normal_y, normal_x};

endmodule

>>> hdl/awvn_ctrl.sv
// sequencing state machine of the vertex normals block
module awvn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_action,
   output logic                   req_ready,
   input  awvn_pkg::awvn_stat_type stat,
   output awvn_pkg::awvn_cmd_type  cmd
);
   import awvn_pkg::*;

   awvn_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       comp_ff, comp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (cnt_ff == CNT_W'(NODES - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               unique case (awvn_action_type'(req_action))
                  ACT_CLEAR: state_in = ST_CLEAR;
                  ACT_LOAD:  state_in = ST_LOAD;
                  ACT_TRI:   state_in = ST_VRD_A;
                  ACT_READ:  state_in = ST_R_RD;
               endcase
            end
         end
         ST_LOAD:     state_in = ST_IDLE;
         ST_VRD_A:    state_in = stat.tri_ok ? ST_VRD_B : ST_IDLE;
         ST_VRD_B:    state_in = ST_VRD_C;
         ST_VRD_C:    state_in = ST_DIFF;
         ST_DIFF:     state_in = ST_CROSS;
         ST_CROSS:    if (cnt_ff == CNT_W'(3)) state_in = ST_ACC_RD;
         ST_ACC_RD:   state_in = ST_ACC_WR;
         ST_ACC_WR:   state_in = (comp_ff == CORNER_LAST) ? ST_IDLE : ST_ACC_RD;
         ST_R_RD:     state_in = stat.a_ok ? ST_R_MAG : ST_RSP;
         ST_R_MAG:    state_in = ST_SHIFT;
         ST_SHIFT: begin
            priority if (stat.zero) state_in = ST_RSP;
            else if (!stat.need_shift) state_in = ST_SQUARE;
         end
         ST_SQUARE:   if (cnt_ff == CNT_W'(3)) state_in = ST_SQRT;
         ST_SQRT:     if (cnt_ff == CNT_W'(ROOT_W - 1)) state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV_IT;
         ST_DIV_IT:   if (cnt_ff == CNT_W'(QUO_W - 1)) state_in = ST_DIV_END;
         ST_DIV_END:  state_in = (comp_ff == CORNER_LAST) ? ST_RSP : ST_DIV_INIT;
         ST_RSP:      if (!stat.rsp_busy) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // step counter restarts on every state change; corner counter clears in idle and advances per corner
   always_comb begin
      cnt_in  = (state_in != state_ff) ? '0 : cnt_ff + CNT_W'(1);
      comp_in = comp_ff;
      if (state_ff == ST_IDLE) comp_in = '0;
      else if ((state_ff == ST_ACC_WR && state_in == ST_ACC_RD) ||
               (state_ff == ST_DIV_END && state_in == ST_DIV_INIT))
         comp_in = comp_ff + 2'd1;
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.cnt    = cnt_ff;
      cmd.corner = comp_ff;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_CLEAR:    cmd.acc_clear = 1'b1;
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.capture_req = req_valid;
         end
         ST_LOAD:     cmd.vtx_write = stat.a_ok;
         ST_VRD_A:    cmd.vtx_read = stat.tri_ok;
         ST_VRD_B: begin
            cmd.vtx_read = 1'b1;
            cmd.cap_a    = 1'b1;
            cmd.corner   = 2'd1;
         end
         ST_VRD_C: begin
            cmd.vtx_read = 1'b1;
            cmd.cap_b    = 1'b1;
            cmd.corner   = 2'd2;
         end
         ST_DIFF:     cmd.diff = 1'b1;
         ST_CROSS:    cmd.cross_step = 1'b1;
         ST_ACC_RD:   cmd.acc_read = 1'b1;
         ST_ACC_WR:   cmd.acc_write = 1'b1;
         ST_R_RD: begin
            cmd.acc_read = stat.a_ok;
            cmd.res_oor  = !stat.a_ok;
         end
         ST_R_MAG:    cmd.mag_load = 1'b1;
         ST_SHIFT:    cmd.shift = stat.need_shift && !stat.zero;
         ST_SQUARE:   cmd.sq_step = 1'b1;
         ST_SQRT:     cmd.sqrt_step = 1'b1;
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV_IT:   cmd.div_step = 1'b1;
         ST_DIV_END:  cmd.q_store = 1'b1;
         ST_RSP:      cmd.rsp_load = !stat.rsp_busy;
         default:     cmd = '0;
      endcase
   end

endmodule

>>> hdl/awvn_datapath.sv
// memories, cross product, accumulate and normalize datapath
module awvn_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [awvn_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [awvn_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [awvn_pkg::COORD_W-1:0] req_pos_z,
   input  logic [awvn_pkg::ADDR_W-1:0]         req_node_a,
   input  logic [awvn_pkg::ADDR_W-1:0]         req_node_b,
   input  logic [awvn_pkg::ADDR_W-1:0]         req_node_c,
   input  awvn_pkg::awvn_cmd_type              cmd,
   output awvn_pkg::awvn_stat_type             stat,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [awvn_pkg::NORM_W-1:0]  rsp_normal_x,
   output logic signed [awvn_pkg::NORM_W-1:0]  rsp_normal_y,
   output logic signed [awvn_pkg::NORM_W-1:0]  rsp_normal_z,
   output logic                                rsp_degenerate,
   output logic                                rsp_saturated
);
   import awvn_pkg::*;

   localparam logic [QUO_W-1:0] HALF = QUO_W'(1) << (NORM_W - 1);
   localparam logic [BIT_W-1:0] BIT_INIT = BIT_W'(1) << (BIT_W - 1);

   function automatic logic node_ok(input logic [ADDR_W-1:0] idx);
      return ({1'b0, idx} < (ADDR_W + 1)'(NODES));
   endfunction

   function automatic logic [NORM_W-1:0] clamp_q(input logic [QUO_W-1:0] q,
                                                 input logic neg);
      logic [QUO_W-1:0] qc;
      if (neg) begin
         qc = (q > HALF) ? HALF : q;
         return NORM_W'(~qc + QUO_W'(1));
      end
      qc = (q > HALF - QUO_W'(1)) ? HALF - QUO_W'(1) : q;
      return qc[NORM_W-1:0];
   endfunction

   // latched request
   logic signed [COORD_W-1:0] pos_ff [3];
   logic [ADDR_W-1:0]         node_ff [3];
   logic [ADDR_W-1:0]         node_sel;

   always_ff @(posedge clock) begin
      if (cmd.capture_req) begin
         pos_ff[0]  <= req_pos_x;
         pos_ff[1]  <= req_pos_y;
         pos_ff[2]  <= req_pos_z;
         node_ff[0] <= req_node_a;
         node_ff[1] <= req_node_b;
         node_ff[2] <= req_node_c;
      end
   end

   always_comb begin
      case (cmd.corner)
         2'd1:    node_sel = node_ff[1];
         2'd2:    node_sel = node_ff[2];
         default: node_sel = node_ff[0];
      endcase
   end

   // vertex position memory
   logic [VTX_W-1:0]  vtx_mem [NODES];
   logic [VTX_W-1:0]  vtx_q_ff;
   logic [ADDR_W-1:0] vtx_addr;

   assign vtx_addr = cmd.vtx_write ? node_ff[0] : node_sel;

   always_ff @(posedge clock) begin
      if (cmd.vtx_write) vtx_mem[vtx_addr] <= {pos_ff[2], pos_ff[1], pos_ff[0]};
      if (cmd.vtx_read) vtx_q_ff <= vtx_mem[vtx_addr];
   end

   // edge vectors and cross product
   logic signed [COORD_W-1:0] pa_ff [3];
   logic signed [COORD_W-1:0] pb_ff [3];
   logic signed [DIFF_W-1:0]  u_ff [3];
   logic signed [DIFF_W-1:0]  v_ff [3];
   logic signed [PROD_W-1:0]  p1_ff, p2_ff;
   logic signed [CROSS_W-1:0] cross_ff [3];
   logic signed [DIFF_W-1:0]  a1, b1, a2, b2;

   always_comb begin
      case (cmd.cnt[1:0])
         2'd1: begin a1 = u_ff[2]; b1 = v_ff[0]; a2 = u_ff[0]; b2 = v_ff[2]; end
         2'd2: begin a1 = u_ff[0]; b1 = v_ff[1]; a2 = u_ff[1]; b2 = v_ff[0]; end
         default: begin a1 = u_ff[1]; b1 = v_ff[2]; a2 = u_ff[2]; b2 = v_ff[1]; end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.cap_a) pa_ff[i] <= vtx_q_ff[i*COORD_W +: COORD_W];
         if (cmd.cap_b) pb_ff[i] <= vtx_q_ff[i*COORD_W +: COORD_W];
         if (cmd.diff) begin
            u_ff[i] <= $signed({pb_ff[i][COORD_W-1], pb_ff[i]}) -
                       $signed({pa_ff[i][COORD_W-1], pa_ff[i]});
            v_ff[i] <= $signed({vtx_q_ff[i*COORD_W + COORD_W - 1],
                                vtx_q_ff[i*COORD_W +: COORD_W]}) -
                       $signed({pa_ff[i][COORD_W-1], pa_ff[i]});
         end
         if (cmd.cross_step && cmd.cnt[1:0] == 2'(i + 1))
            cross_ff[i] <= $signed({p1_ff[PROD_W-1], p1_ff}) -
                           $signed({p2_ff[PROD_W-1], p2_ff});
      end
      if (cmd.cross_step && cmd.cnt[1:0] != 2'd3) begin
         p1_ff <= a1 * b1;
         p2_ff <= a2 * b2;
      end
   end

   // accumulator memory, clip mark in the top bit
   logic [ACC_ENT_W-1:0] acc_mem [NODES];
   logic [ACC_ENT_W-1:0] acc_q_ff;
   logic [ACC_ENT_W-1:0] acc_new, acc_wdata;
   logic [ADDR_W-1:0]    acc_addr;
   logic signed [ACC_W:0] acc_sum [3];
   logic [2:0]           clip;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_sum[i] = $signed({acc_q_ff[i*ACC_W + ACC_W - 1], acc_q_ff[i*ACC_W +: ACC_W]}) +
                      $signed({{(ACC_W + 1 - CROSS_W){cross_ff[i][CROSS_W-1]}}, cross_ff[i]});
         clip[i] = acc_sum[i][ACC_W] != acc_sum[i][ACC_W-1];
         if (clip[i])
            acc_new[i*ACC_W +: ACC_W] = acc_sum[i][ACC_W] ?
                                        {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
         else
            acc_new[i*ACC_W +: ACC_W] = acc_sum[i][ACC_W-1:0];
      end
      acc_new[ACC_ENT_W-1] = acc_q_ff[ACC_ENT_W-1] | (|clip);
   end

   assign acc_addr  = cmd.acc_clear ? cmd.cnt[ADDR_W-1:0] : node_sel;
   assign acc_wdata = cmd.acc_clear ? '0 : acc_new;

   always_ff @(posedge clock) begin
      if (cmd.acc_clear || cmd.acc_write) acc_mem[acc_addr] <= acc_wdata;
      if (cmd.acc_read) acc_q_ff <= acc_mem[acc_addr];
   end

   // magnitudes and range reduction
   logic [ACC_W-1:0] mag_ff [3];
   logic             neg_ff [3];
   logic [MAG_W-1:0] mag_sel;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.mag_load) begin
            neg_ff[i] <= acc_q_ff[i*ACC_W + ACC_W - 1];
            mag_ff[i] <= acc_q_ff[i*ACC_W + ACC_W - 1] ?
                         ACC_W'(0) - acc_q_ff[i*ACC_W +: ACC_W] :
                         acc_q_ff[i*ACC_W +: ACC_W];
         end else if (cmd.shift) begin
            mag_ff[i] <= mag_ff[i] >> 1;
         end
      end
   end

   always_comb begin
      case (cmd.cnt[1:0] | {2{cmd.div_init}} & cmd.corner)
         2'd1:    mag_sel = mag_ff[1][MAG_W-1:0];
         2'd2:    mag_sel = mag_ff[2][MAG_W-1:0];
         default: mag_sel = mag_ff[0][MAG_W-1:0];
      endcase
   end

   // sum of squares and bitwise square root
   logic [SQ_W-1:0]   sq_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  rad_ff;
   logic [BIT_W-1:0]  root_ff, bit_ff, trial;
   logic [ROOT_W-1:0] len;

   assign trial = root_ff + bit_ff;
   assign len   = (root_ff[ROOT_W-1:0] == '0) ? ROOT_W'(1) : root_ff[ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.sq_step) begin
         if (cmd.cnt[1:0] != 2'd3) sq_ff <= mag_sel * mag_sel;
         if (cmd.cnt[1:0] == 2'd0) sum_ff <= '0;
         else sum_ff <= sum_ff + SUM_W'(sq_ff);
         if (cmd.cnt[1:0] == 2'd3) begin
            rad_ff  <= sum_ff + SUM_W'(sq_ff);
            root_ff <= '0;
            bit_ff  <= BIT_INIT;
         end
      end
      if (cmd.sqrt_step) begin
         if ({1'b0, rad_ff} >= trial) begin
            rad_ff  <= SUM_W'({1'b0, rad_ff} - trial);
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // restoring divider, rounded quotient of one component
   logic [NUM_W-1:0]  num;
   logic [ROOT_W-1:0] rem_ff;
   logic [QUO_W-1:0]  num_lo_ff, quo_ff;
   logic [ROOT_W:0]   rem_shift;

   assign num       = NUM_W'({mag_sel, {(NORM_W-1){1'b0}}}) + NUM_W'(len >> 1);
   assign rem_shift = {rem_ff, num_lo_ff[QUO_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff    <= ROOT_W'(num >> QUO_W);
         num_lo_ff <= num[QUO_W-1:0];
         quo_ff    <= '0;
      end else if (cmd.div_step) begin
         num_lo_ff <= num_lo_ff << 1;
         if (rem_shift >= {1'b0, len}) begin
            rem_ff <= ROOT_W'(rem_shift - {1'b0, len});
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[ROOT_W-1:0];
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   // result assembly and output register
   logic [NORM_W-1:0] res_n_ff [3];
   logic              res_degen_ff, res_sat_ff;
   logic              rsp_valid_ff;
   logic [NORM_W-1:0] rsp_n_ff [3];
   logic              rsp_degen_ff, rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (cmd.res_oor || cmd.mag_load) begin
         for (int i = 0; i < 3; i++) res_n_ff[i] <= '0;
         res_degen_ff <= 1'b1;
         res_sat_ff   <= cmd.mag_load & acc_q_ff[ACC_ENT_W-1];
      end
      if (cmd.q_store) begin
         for (int i = 0; i < 3; i++)
            if (cmd.corner == 2'(i)) res_n_ff[i] <= clamp_q(quo_ff, neg_ff[i]);
         res_degen_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         for (int i = 0; i < 3; i++) rsp_n_ff[i] <= res_n_ff[i];
         rsp_degen_ff <= res_degen_ff;
         rsp_sat_ff   <= res_sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = rsp_n_ff[0];
   assign rsp_normal_y   = rsp_n_ff[1];
   assign rsp_normal_z   = rsp_n_ff[2];
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_saturated  = rsp_sat_ff;

   always_comb begin
      stat.a_ok       = node_ok(node_ff[0]);
      stat.tri_ok     = node_ok(node_ff[0]) & node_ok(node_ff[1]) & node_ok(node_ff[2]);
      stat.zero       = (mag_ff[0] == '0) && (mag_ff[1] == '0) && (mag_ff[2] == '0);
      stat.need_shift = (mag_ff[0][ACC_W-1:MAG_W] != '0) ||
                        (mag_ff[1][ACC_W-1:MAG_W] != '0) ||
                        (mag_ff[2][ACC_W-1:MAG_W] != '0);
      stat.rsp_busy   = rsp_valid_ff & ~rsp_ready;
   end

endmodule

>>> tb/testbench.sv
// self-checking testbench for the area weighted vertex normals core
`timescale 1ns / 100ps

class normal_scoreboard;
   localparam longint ACC_MAX = (64'sd1 <<< 55) - 1;
   localparam longint ACC_MIN = -(64'sd1 <<< 55);

   longint vx[1024], vy[1024], vz[1024];
   longint ax[1024], ay[1024], az[1024];
   bit clip[1024];
   bit [49:0] pending_normals[$];
   int mismatches;
   int errors;

   function void clear_accums();
      foreach (ax[i]) begin
         ax[i] = 0; ay[i] = 0; az[i] = 0; clip[i] = 0;
      end
   endfunction

   // saturating add of a cross product component, returns 1 on clip
   function bit sat_add(ref longint acc, input longint d);
      logic signed [65:0] s;
      s = 66'(acc) + 66'(d);
      if (s > ACC_MAX) begin
         acc = ACC_MAX; return 1;
      end
      if (s < ACC_MIN) begin
         acc = ACC_MIN; return 1;
      end
      acc = longint'(s);
      return 0;
   endfunction

   function bit [15:0] scale(longint mag, bit neg, longint len);
      longint q;
      q = ((mag <<< 15) + len / 2) / len;
      if (neg) begin
         if (q > 32768) q = 32768;
         return 16'(-q);
      end
      if (q > 32767) q = 32767;
      return 16'(q);
   endfunction

   function longint int_sqrt(longint x);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > x) b = b >>> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b); r = (r >>> 1) + b;
         end else r = r >>> 1;
         b = b >>> 2;
      end
      return r;
   endfunction

   function void note_request(awvn_pkg::awvn_action_type act, bit [103:0] d);
      int a, b, c;
      longint ux, uy, uz, wx, wy, wz, cx, cy, cz, m, len;
      longint mag[3];
      bit neg[3];
      bit [49:0] rsp;
      bit cl;
      int k[3];
      int s;
      a = d[81:72]; b = d[91:82]; c = d[101:92];
      case (act)
         awvn_pkg::ACT_CLEAR: clear_accums();
         awvn_pkg::ACT_LOAD: begin
            vx[a] = longint'(signed'(d[23:0]));
            vy[a] = longint'(signed'(d[47:24]));
            vz[a] = longint'(signed'(d[71:48]));
         end
         awvn_pkg::ACT_TRI: begin
            ux = vx[b] - vx[a]; uy = vy[b] - vy[a]; uz = vz[b] - vz[a];
            wx = vx[c] - vx[a]; wy = vy[c] - vy[a]; wz = vz[c] - vz[a];
            // each product fits 50 bits, the difference fits 64
            cx = uy * wz - uz * wy;
            cy = uz * wx - ux * wz;
            cz = ux * wy - uy * wx;
            k[0] = a; k[1] = b; k[2] = c;
            for (int i = 0; i < 3; i++) begin
               cl = sat_add(ax[k[i]], cx);
               cl |= sat_add(ay[k[i]], cy);
               cl |= sat_add(az[k[i]], cz);
               if (cl) clip[k[i]] = 1;
            end
         end
         default: begin
            rsp = '0;
            mag[0] = ax[a]; mag[1] = ay[a]; mag[2] = az[a];
            m = 0;
            for (int i = 0; i < 3; i++) begin
               neg[i] = mag[i] < 0;
               if (neg[i]) mag[i] = -mag[i];
               if (mag[i] > m) m = mag[i];
            end
            rsp[49] = clip[a];
            rsp[48] = 1;
            if (m != 0) begin
               s = 0;
               while ((m >>> s) >= (64'sd1 <<< 30)) s++;
               for (int i = 0; i < 3; i++) mag[i] = mag[i] >>> s;
               len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
               if (len == 0) len = 1;
               rsp[15:0] = scale(mag[0], neg[0], len);
               rsp[31:16] = scale(mag[1], neg[1], len);
               rsp[47:32] = scale(mag[2], neg[2], len);
               rsp[48] = 0;
            end
            pending_normals = {pending_normals, rsp};
         end
      endcase
   endfunction

   function void check_normal(bit [55:0] got);
      bit [49:0] want;
      if (pending_normals.size() == 0) begin
         errors++;
         if (mismatches++ < 10) $display("unexpected result %h", got);
         return;
      end
      want = pending_normals.pop_front();
      if (got[15:0] !== want[15:0] || got[31:16] !== want[31:16] ||
          got[47:32] !== want[47:32] || got[48] !== want[48] ||
          got[49] !== want[49] || got[55:50] !== '0) begin
         errors++;
         if (mismatches++ < 10) $display("normal exp %h got %h", want, got[49:0]);
      end
   endfunction
endclass

module testbench;
   import awvn_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [1:0]   req_tuser = ACT_CLEAR;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [55:0]  rsp_tdata;

   normal_scoreboard board = new();
   bit written[1024];
   int loaded_list[$];
   bit sink_hold = 0;
   bit stimulus_done = 0;
   int idle_cycles = 0;

   area_weighted_vertex_normals_core uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // sink: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (reset || sink_hold) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 99) < 3);
      if (!reset && rsp_tvalid && rsp_tready) board.check_normal(rsp_tdata);
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("area_weighted_vertex_normals_core: mismatch");
         $finish;
      end
   end

   task automatic send(awvn_action_type act, bit [103:0] d);
      req_tvalid <= 1;
      req_tuser <= act;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(act, d);
      if (act == ACT_LOAD && d[81:72] < 1024 && !written[d[81:72]]) begin
         written[d[81:72]] = 1;
         loaded_list = {loaded_list, int'(d[81:72])};
      end
   endtask

   task automatic pause(int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   function automatic bit [103:0] pack(bit [23:0] x, bit [23:0] y, bit [23:0] z,
                                       bit [9:0] a, bit [9:0] b, bit [9:0] c);
      return {2'b0, c, b, a, z, y, x};
   endfunction

   function automatic int pick_vertex();
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   task automatic send_random();
      int r;
      bit [9:0] a;
      r = $urandom_range(0, 99);
      a = 10'(pick_vertex());
      if (r < 2) send(ACT_CLEAR, 104'({$urandom, $urandom, $urandom, $urandom}));
      else if (r < 25) send(ACT_LOAD, pack(
         ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65535) - 32768),
         ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65535) - 32768),
         ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65535) - 32768),
         ($urandom_range(0, 2) == 0) ? 10'($urandom) : a, 10'($urandom), 10'($urandom)));
      else if (r < 65) send(ACT_TRI, pack(24'($urandom), 24'($urandom), 24'($urandom),
                                           10'(pick_vertex()), 10'(pick_vertex()),
                                           10'(pick_vertex())));
      else send(ACT_READ, pack(24'($urandom), 24'($urandom), 24'($urandom),
                               ($urandom_range(0, 9) == 0) ? 10'($urandom) : a,
                               10'($urandom), 10'($urandom)));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes of positions, every action, special cases
      send(ACT_READ, pack(0, 0, 0, 10'd5, 0, 0));           // degenerate, zero accum
      send(ACT_LOAD, pack(24'h800000, 24'h800000, 24'h800000, 10'd0, 0, 0));
      send(ACT_LOAD, pack(24'h7fffff, 24'h800000, 24'h7fffff, 10'd1, 0, 0));
      send(ACT_LOAD, pack(24'h800000, 24'h7fffff, 24'h7fffff, 10'd1023, 0, 0));
      send(ACT_LOAD, pack(24'h001000, 24'h0, 24'h0, 10'd2, 0, 0));
      send(ACT_LOAD, pack(24'h0, 24'h001000, 24'h0, 10'd3, 0, 0));
      send(ACT_TRI, pack(0, 0, 0, 10'd0, 10'd2, 10'd3));
      send(ACT_READ, pack(0, 0, 0, 10'd2, 0, 0));
      for (int i = 0; i < 12; i++)                          // large repeated triangle
         send(ACT_TRI, pack(0, 0, 0, 10'd0, 10'd1, 10'd1023));
      send(ACT_READ, pack(0, 0, 0, 10'd1023, 0, 0));
      send(ACT_READ, pack(0, 0, 0, 10'd0, 0, 0));
      send(ACT_TRI, pack(0, 0, 0, 10'd2, 10'd2, 10'd3));    // repeated corner
      send(ACT_READ, pack(0, 0, 0, 10'd2, 0, 0));
      send(ACT_CLEAR, '1);
      send(ACT_READ, pack(0, 0, 0, 10'd0, 0, 0));           // clip mark cleared
      // random part in bursts with gaps
      for (int n = 0; n < 1300; ) begin
         int burst;
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst; i++) begin
            send_random();
            n++;
         end
         if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
         if (n > 400 && n < 431) begin
            // long receiver hold-off while requests keep coming
            sink_hold = 1;
            fork
               begin
                  repeat (500) @(posedge clock);
                  sink_hold = 0;
               end
            join_none
            for (int i = 0; i < 20; i++)
               send(ACT_READ, pack(0, 0, 0, 10'(pick_vertex()), 0, 0));
            n += 20;
         end
         if (n > 800 && n < 831) begin
            pause(1);
            while (board.pending_normals.size() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 0;
      stimulus_done = 1;
      while (board.pending_normals.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) $display("area_weighted_vertex_normals_core: match");
      else $display("area_weighted_vertex_normals_core: mismatch");
      $finish;
   end
endmodule

>>> area_weighted_vertex_normals_core.f
hdl/awvn_pkg.sv
hdl/awvn_ctrl.sv
hdl/awvn_datapath.sv
hdl/area_weighted_vertex_normals_core.sv
tb/testbench.sv
